// File: design/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared widths, constants and the result record for the gzip member
// header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  localparam int unsigned PosW = 25;
  localparam int unsigned SkipW = 16;

  // Largest member length counted; the position counter saturates here.
  localparam logic [PosW-1:0] MaxMemberBytes = 25'd16777216;

  localparam logic [7:0] Magic0 = 8'h1f;
  localparam logic [7:0] Magic1 = 8'h8b;
  localparam logic [7:0] MethodDeflate = 8'h08;

  localparam logic [PosW-1:0] MinMemberBytes = 25'd18;
  localparam logic [PosW-1:0] TrailerBytes = 25'd8;

  // Status codes of the summary.
  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StShort = 3'd1;
  localparam logic [2:0] StBadMagic = 3'd2;
  localparam logic [2:0] StTrunc = 3'd3;
  localparam logic [2:0] StOversize = 3'd4;

  typedef struct packed {
    logic            kind;
    logic [7:0]      name_byte;
    logic [2:0]      status;
    logic [PosW-1:0] deflate_offset;
    logic [PosW-1:0] payload_size;
    logic            last;
  } result_t;

endpackage

// File: design/gzhp_in_reg.sv
// ----------------------------------------------------------------------------
// gzhp_in_reg
// Input register: holds one accepted member byte until the parser takes it.
// ----------------------------------------------------------------------------
module gzhp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o,
  output logic       is_last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_byte_i;
      last_q <= is_last_i;
    end
  end

  assign valid_o     = valid_q;
  assign data_byte_o = data_q;
  assign is_last_o   = last_q;

endmodule

// File: design/gzhp_parser.sv
// ----------------------------------------------------------------------------
// gzhp_parser
// Header phase tracking and summary computation, one byte per step.
// ----------------------------------------------------------------------------
module gzhp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_byte_i,
  input  logic              is_last_i,
  output logic              has_result_o,
  output gzhp_pkg::result_t result_o
);
  import gzhp_pkg::*;

  localparam logic [3:0] PhFixed   = 4'd0;
  localparam logic [3:0] PhXlo     = 4'd1;
  localparam logic [3:0] PhXhi     = 4'd2;
  localparam logic [3:0] PhXskip   = 4'd3;
  localparam logic [3:0] PhName    = 4'd4;
  localparam logic [3:0] PhComment = 4'd5;
  localparam logic [3:0] PhHcrc    = 4'd6;
  localparam logic [3:0] PhPayload = 4'd7;

  // Sections: 0 fixed, 1 extra, 2 name, 3 comment, 4 header CRC.
  localparam logic [2:0] SecFixed   = 3'd0;
  localparam logic [2:0] SecExtra   = 3'd1;
  localparam logic [2:0] SecName    = 3'd2;
  localparam logic [2:0] SecComment = 3'd3;
  localparam logic [2:0] SecHcrc    = 3'd4;

  // Flag bits as latched: bit0 FHCRC, bit1 FEXTRA, bit2 FNAME, bit3 FCOMMENT.
  function automatic logic [3:0] next_phase(input logic [2:0] done,
                                            input logic [3:0] flags);
    logic [3:0] ph;
    ph = PhPayload;
    if (done < SecExtra && flags[1]) begin
      ph = PhXlo;
    end else if (done < SecName && flags[2]) begin
      ph = PhName;
    end else if (done < SecComment && flags[3]) begin
      ph = PhComment;
    end else if (done < SecHcrc && flags[0]) begin
      ph = PhHcrc;
    end
    return ph;
  endfunction

  logic [PosW-1:0]  pos_q, pos_d, pos_inc;
  logic [3:0]       phase_q, phase_d;
  logic [3:0]       flags_q, flags_d;
  logic [SkipW-1:0] skip_q, skip_d, skip_dec;
  logic [7:0]       xlo_q, xlo_d;
  logic             bad_q, bad_d;
  logic [PosW-1:0]  pstart_q, pstart_d;
  logic             ovs_q, ovs_d;

  logic             call_next;
  logic [2:0]       done_sec;
  logic             emit_name;
  logic [PosW-1:0]  p;
  logic [PosW:0]    payload_end;
  logic             trunc;
  logic [2:0]       status;

  assign skip_dec = skip_q - {{(SkipW-1){1'b0}}, (skip_q != '0)};

  always_comb begin
    p         = pos_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    flags_d   = flags_q;
    skip_d    = skip_q;
    xlo_d     = xlo_q;
    bad_d     = bad_q;
    pstart_d  = pstart_q;
    ovs_d     = ovs_q || (p >= MaxMemberBytes);
    call_next = 1'b0;
    done_sec  = SecFixed;
    emit_name = 1'b0;

    unique case (phase_q)
      PhFixed: begin
        if (p == 25'd0 && data_byte_i != Magic0) bad_d = 1'b1;
        if (p == 25'd1 && data_byte_i != Magic1) bad_d = 1'b1;
        if (p == 25'd2 && data_byte_i != MethodDeflate) bad_d = 1'b1;
        if (p == 25'd3) flags_d = data_byte_i[4:1];
        if (p == 25'd9) begin
          call_next = 1'b1;
          done_sec  = SecFixed;
        end
      end
      PhXlo: begin
        xlo_d   = data_byte_i;
        phase_d = PhXhi;
      end
      PhXhi: begin
        skip_d = {data_byte_i, xlo_q};
        if ({data_byte_i, xlo_q} == '0) begin
          call_next = 1'b1;
          done_sec  = SecExtra;
        end else begin
          phase_d = PhXskip;
        end
      end
      PhXskip: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          call_next = 1'b1;
          done_sec  = SecExtra;
        end
      end
      PhName: begin
        if (data_byte_i == 8'd0) begin
          call_next = 1'b1;
          done_sec  = SecName;
        end else if (!bad_q && !is_last_i) begin
          emit_name = 1'b1;
        end
      end
      PhComment: begin
        if (data_byte_i == 8'd0) begin
          call_next = 1'b1;
          done_sec  = SecComment;
        end
      end
      PhHcrc: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          call_next = 1'b1;
          done_sec  = SecHcrc;
        end
      end
      default: begin
      end
    endcase

    if (call_next) begin
      phase_d = next_phase(done_sec, flags_d);
      if (phase_d == PhHcrc) skip_d = 16'd2;
      if (phase_d == PhPayload) pstart_d = p + 25'd1;
    end

    pos_inc = (p < MaxMemberBytes) ? p + 25'd1 : p;
    pos_d   = pos_inc;

    // The payload must leave room for the trailer after the header ends.
    payload_end = {1'b0, pstart_d} + {1'b0, TrailerBytes};
    trunc       = (phase_d != PhPayload) || (payload_end > {1'b0, pos_inc});

    if (pos_inc < MinMemberBytes) begin
      status = StShort;
    end else if (bad_d) begin
      status = StBadMagic;
    end else if (ovs_d) begin
      status = StOversize;
    end else if (trunc) begin
      status = StTrunc;
    end else begin
      status = StOk;
    end

    result_o = '0;
    if (is_last_i) begin
      result_o.kind   = 1'b1;
      result_o.status = status;
      result_o.last   = 1'b1;
      if (status == StOk) begin
        result_o.deflate_offset = pstart_d;
        result_o.payload_size   = pos_inc - pstart_d - TrailerBytes;
      end
    end else if (emit_name) begin
      result_o.name_byte = data_byte_i;
    end
    has_result_o = is_last_i || emit_name;

    // The final byte of a member returns everything to the reset state.
    if (is_last_i) begin
      pos_d    = '0;
      phase_d  = PhFixed;
      flags_d  = '0;
      skip_d   = '0;
      xlo_d    = '0;
      bad_d    = 1'b0;
      pstart_d = '0;
      ovs_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PhFixed;
      flags_q  <= '0;
      skip_q   <= '0;
      xlo_q    <= '0;
      bad_q    <= 1'b0;
      pstart_q <= '0;
      ovs_q    <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      skip_q   <= skip_d;
      xlo_q    <= xlo_d;
      bad_q    <= bad_d;
      pstart_q <= pstart_d;
      ovs_q    <= ovs_d;
    end
  end

endmodule

// File: design/gzhp_out_reg.sv
// ----------------------------------------------------------------------------
// gzhp_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module gzhp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gzhp_pkg::result_t result_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gzhp_pkg::result_t result_o
);
  import gzhp_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// File: design/gzip_member_header_parser.sv
// ----------------------------------------------------------------------------
// gzip_member_header_parser
// Walks the header of one gzip member byte by byte, streams file-name bytes
// and reports status on the final byte, with payload offset and size if OK.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   data_byte_i, is_last_i
//   out      output     out_valid_o/out_ready_i kind_o, name_byte_o, status_o,
//                                               deflate_offset_o,
//                                               payload_size_o, last_o
//
// One byte is taken per cycle, except while a byte that makes a result is
// held back by a full result register. The byte is held in the input
// register, then the result waits in the result register until it is taken.
// Reset clears the valid flags and the parse state; the first byte after
// reset is taken as the first magic byte of a member.
// When the result register is full and not drained, a byte that makes a
// result waits in the input register; bytes that make no result still flow.
// ----------------------------------------------------------------------------
module gzip_member_header_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      is_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic [7:0]                name_byte_o,
  output logic [2:0]                status_o,
  output logic [gzhp_pkg::PosW-1:0] deflate_offset_o,
  output logic [gzhp_pkg::PosW-1:0] payload_size_o,
  output logic                      last_o
);
  import gzhp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_last;
  logic       advance;
  logic       has_result;
  logic       out_free;
  result_t    step_res;
  result_t    out_res;

  assign advance = byte_valid && (out_free || !has_result);

  gzhp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .advance_i   (advance),
    .valid_o     (byte_valid),
    .data_byte_o (byte_data),
    .is_last_o   (byte_last)
  );

  gzhp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (byte_data),
    .is_last_i    (byte_last),
    .has_result_o (has_result),
    .result_o     (step_res)
  );

  gzhp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign kind_o           = out_res.kind;
  assign name_byte_o      = out_res.name_byte;
  assign status_o         = out_res.status;
  assign deflate_offset_o = out_res.deflate_offset;
  assign payload_size_o   = out_res.payload_size;
  assign last_o           = out_res.last;

endmodule
